// ===== rtl/esc_pkg.sv =====
// shared types, constants and the month-length table for the epoch to calendar unit
// no dependencies
`timescale 1ns / 1ps

package esc_pkg;

    localparam logic [31:0] LAST_VALID_SECOND = 32'd4102444799;
    localparam logic [31:0] SECS_PER_MINUTE   = 32'd60;
    localparam logic [31:0] SECS_PER_HOUR     = 32'd3600;
    localparam logic [31:0] SECS_PER_DAY      = 32'd86400;
    localparam logic [31:0] SECS_COMMON_YEAR  = 32'd31536000;
    localparam logic [31:0] SECS_LEAP_YEAR    = 32'd31622400;
    localparam logic [11:0] FIRST_YEAR        = 12'd1970;
    localparam logic [3:0]  LAST_MONTH        = 4'd11;

    // reciprocals for the odd factor of each divisor after the power of two is shifted out
    // day:    86400 = 2^7 * 675, ceil(2^28 / 675), exact for a 18-bit dividend
    // hour:   3600  = 2^4 * 225, ceil(2^21 / 225), exact for a 13-bit dividend
    // minute: 60    = 2^2 * 15,  ceil(2^14 / 15),  exact for a 10-bit dividend
    localparam logic [18:0] DAY_RECIP  = 19'd397683;
    localparam logic [13:0] HOUR_RECIP = 14'd9321;
    localparam logic [10:0] MIN_RECIP  = 11'd1093;

    typedef enum logic [2:0] {
        S_IDLE,
        S_YEAR,
        S_DAY,
        S_HOUR,
        S_MIN,
        S_MONTH,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_HOUR,
        DIV_MIN
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     year_step;
        logic     div_step;
        t_div_sel div_sel;
        logic     div_bit;    // 1: take quotient, 0: take off quotient times divisor
        logic     month_step;
        logic     finish;
    } t_dp_cmd;

    typedef struct packed {
        logic oor;
        logic year_done;
        logic month_done;
    } t_dp_status;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        begin
            unique case (m)
                4'd0:    len = 5'd31;
                4'd1:    len = leap ? 5'd29 : 5'd28;
                4'd2:    len = 5'd31;
                4'd3:    len = 5'd30;
                4'd4:    len = 5'd31;
                4'd5:    len = 5'd30;
                4'd6:    len = 5'd31;
                4'd7:    len = 5'd31;
                4'd8:    len = 5'd30;
                4'd9:    len = 5'd31;
                4'd10:   len = 5'd30;
                4'd11:   len = 5'd31;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

    function automatic logic [31:0] div_const(input t_div_sel sel);
        logic [31:0] d;
        begin
            unique case (sel)
                DIV_DAY:  d = SECS_PER_DAY;
                DIV_HOUR: d = SECS_PER_HOUR;
                DIV_MIN:  d = SECS_PER_MINUTE;
                default:  d = SECS_PER_DAY;
            endcase
            return d;
        end
    endfunction

endpackage

// ===== rtl/esc_datapath.sv =====
// datapath: seconds remainder, year counter, reciprocal dividers and month walk
// depends on esc_pkg
`timescale 1ns / 1ps

module esc_datapath import esc_pkg::*; (
    input  logic        i_clk,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    input  logic [31:0] i_epoch_seconds,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic        o_out_of_range
);

    logic [31:0] r_secs, n_secs;
    logic [11:0] r_year, n_year;
    logic        r_oor, n_oor;
    logic [8:0]  r_days, n_days;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_min, n_min;
    logic [3:0]  r_month, n_month;

    logic [11:0] r_o_year;
    logic [3:0]  r_o_month;
    logic [4:0]  r_o_day;
    logic [4:0]  r_o_hour;
    logic [5:0]  r_o_min;
    logic        r_o_oor;

    logic        leap;
    logic [31:0] year_len;
    logic [4:0]  mlen;
    logic [36:0] day_prod;
    logic [26:0] hour_prod;
    logic [20:0] min_prod;
    logic [8:0]  day_q;
    logic [4:0]  hour_q;
    logic [5:0]  min_q;
    logic [8:0]  div_quot;
    logic [31:0] div_back;

    assign leap     = (r_year[1:0] == 2'b00);
    assign year_len = leap ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
    assign mlen     = month_len(r_month, leap);

    // quotients by reciprocal multiply; the remainder is below one year, one day, one hour
    assign day_prod  = 37'(r_secs[24:7]) * 37'(DAY_RECIP);
    assign hour_prod = 27'(r_secs[16:4]) * 27'(HOUR_RECIP);
    assign min_prod  = 21'(r_secs[11:2]) * 21'(MIN_RECIP);
    assign day_q     = day_prod[36:28];
    assign hour_q    = hour_prod[25:21];
    assign min_q     = min_prod[19:14];

    // quotient taken last cycle, scaled back for the remainder
    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_DAY:  div_quot = r_days;
            DIV_HOUR: div_quot = {4'd0, r_hour};
            DIV_MIN:  div_quot = {3'd0, r_min};
            default:  div_quot = r_days;
        endcase
    end

    assign div_back = 32'(div_quot) * div_const(i_cmd.div_sel);

    assign o_status.oor        = r_oor;
    assign o_status.year_done  = (r_secs < year_len);
    assign o_status.month_done = (r_days < {4'd0, mlen}) || (r_month >= LAST_MONTH);

    always_comb begin
        n_secs  = r_secs;
        n_year  = r_year;
        n_oor   = r_oor;
        n_days  = r_days;
        n_hour  = r_hour;
        n_min   = r_min;
        n_month = r_month;
        if (i_cmd.load) begin
            n_secs  = i_epoch_seconds;
            n_year  = FIRST_YEAR;
            n_oor   = (i_epoch_seconds > LAST_VALID_SECOND);
            n_days  = '0;
            n_hour  = '0;
            n_min   = '0;
            n_month = '0;
        end else if (i_cmd.year_step) begin
            n_secs = r_secs - year_len;
            n_year = r_year + 12'd1;
        end else if (i_cmd.div_step) begin
            // quotient first, then the remainder from it on the next cycle
            if (i_cmd.div_bit) begin
                unique case (i_cmd.div_sel)
                    DIV_DAY:  n_days = day_q;
                    DIV_HOUR: n_hour = hour_q;
                    DIV_MIN:  n_min  = min_q;
                    default:  n_days = r_days;
                endcase
            end else begin
                n_secs = r_secs - div_back;
            end
        end else if (i_cmd.month_step) begin
            n_days  = r_days - {4'd0, mlen};
            n_month = r_month + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_secs  <= n_secs;
        r_year  <= n_year;
        r_oor   <= n_oor;
        r_days  <= n_days;
        r_hour  <= n_hour;
        r_min   <= n_min;
        r_month <= n_month;
        if (i_cmd.finish) begin
            r_o_oor <= r_oor;
            if (r_oor) begin
                r_o_year  <= '0;
                r_o_month <= '0;
                r_o_day   <= '0;
                r_o_hour  <= '0;
                r_o_min   <= '0;
            end else begin
                r_o_year  <= r_year;
                r_o_month <= r_month + 4'd1;
                r_o_day   <= r_days[4:0] + 5'd1;
                r_o_hour  <= r_hour;
                r_o_min   <= r_min;
            end
        end
    end

    assign o_year         = r_o_year;
    assign o_month        = r_o_month;
    assign o_day_of_month = r_o_day;
    assign o_hour         = r_o_hour;
    assign o_minute       = r_o_min;
    assign o_out_of_range = r_o_oor;

endmodule

// ===== rtl/esc_ctrl.sv =====
// controller: sequences year, division and month phases and owns both handshakes
// depends on esc_pkg
`timescale 1ns / 1ps

module esc_ctrl import esc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    t_state     r_state, n_state;
    logic       r_bit, n_bit;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_bit            = r_bit;
        o_cmd.load       = 1'b0;
        o_cmd.year_step  = 1'b0;
        o_cmd.div_step   = 1'b0;
        o_cmd.div_sel    = DIV_DAY;
        o_cmd.div_bit    = r_bit;
        o_cmd.month_step = 1'b0;
        o_cmd.finish     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_YEAR;
                end
            end
            S_YEAR: begin
                if (i_status.oor) begin
                    n_state = S_DONE;
                end else if (i_status.year_done) begin
                    n_bit   = 1'b1;
                    n_state = S_DAY;
                end else begin
                    o_cmd.year_step = 1'b1;
                end
            end
            S_DAY: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_sel  = DIV_DAY;
                if (r_bit == 1'b0) begin
                    n_bit   = 1'b1;
                    n_state = S_HOUR;
                end else begin
                    n_bit = 1'b0;
                end
            end
            S_HOUR: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_sel  = DIV_HOUR;
                if (r_bit == 1'b0) begin
                    n_bit   = 1'b1;
                    n_state = S_MIN;
                end else begin
                    n_bit = 1'b0;
                end
            end
            S_MIN: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_sel  = DIV_MIN;
                if (r_bit == 1'b0) begin
                    n_state = S_MONTH;
                end else begin
                    n_bit = 1'b0;
                end
            end
            S_MONTH: begin
                if (i_status.month_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.month_step = 1'b1;
                end
            end
            S_DONE: begin
                // output register free, or its word leaves this edge
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        priority if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/epoch_seconds_to_calendar_unit.sv =====
// sequence from input word to result word: the year loop steps once per elapsed
// year (up to 129) and then checks, then reciprocal division (quotient, then
// remainder) for day, hour and minute, up to 11 month steps and a check, and a
// hand-off; an out of range word goes from the year check straight to hand-off
// throughput: one word at a time; the next input word is taken once the result
// is in the output register, which may still wait on the downstream stall
// reset: synchronous active-low i_rst_n returns the controller to idle and empties the output
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_unit import esc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_epoch_seconds,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic        o_out_of_range
);

    // command and status between sequencer and datapath
    t_dp_cmd    cmd;
    t_dp_status status;

    // state machine: idle, year loop, three divisions, month walk, hand-off
    esc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // remainder register, counters and the result register
    esc_datapath u_dp (
        .i_clk           (i_clk),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_epoch_seconds (i_epoch_seconds),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day_of_month  (o_day_of_month),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_out_of_range  (o_out_of_range)
    );

endmodule

// ===== rtl/esc_checker.sv =====
// port-level checks for the epoch to calendar unit, bound to the top level
// depends on epoch_seconds_to_calendar_unit
`timescale 1ns / 1ps

module esc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [11:0] o_year,
    input logic [3:0]  o_month,
    input logic [4:0]  o_day_of_month,
    input logic [4:0]  o_hour,
    input logic [5:0]  o_minute,
    input logic        o_out_of_range
);

    // busy right after taking a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    // out of range words carry an all-zero date
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_of_range |->
            o_year == 12'd0 && o_month == 4'd0 && o_day_of_month == 5'd0 &&
            o_hour == 5'd0 && o_minute == 6'd0)
        else $error("out of range word with nonzero date");

    // in range words lie inside the calendar
    a_date_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_of_range |->
            o_year >= 12'd1970 && o_year <= 12'd2099 &&
            o_month >= 4'd1 && o_month <= 4'd12 &&
            o_day_of_month >= 5'd1 && o_hour <= 5'd23 && o_minute <= 6'd59)
        else $error("result date out of calendar");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_year) &&
            $stable(o_month) && $stable(o_day_of_month) && $stable(o_minute))
        else $error("stalled result changed");

endmodule

bind epoch_seconds_to_calendar_unit esc_checker u_esc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_year         (o_year),
    .o_month        (o_month),
    .o_day_of_month (o_day_of_month),
    .o_hour         (o_hour),
    .o_minute       (o_minute),
    .o_out_of_range (o_out_of_range)
);
